@@ rtl/tgad_pkg.sv @@
// Shared types and constants of the TGA stream decoder.
`default_nettype none

package tgad_pkg;

   // Kinds of result record.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes carried by an error record.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BAD_TYPE  = 2'd1;
   localparam logic [1:0] ERR_ZERO_DIM  = 2'd2;
   localparam logic [1:0] ERR_BAD_DEPTH = 2'd3;

   // Depth of the record queue between parser and output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One result record.
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  err;
      logic [15:0] width;
      logic [15:0] height;
      logic [2:0]  pixel_bytes;
      logic        compressed;
      logic [31:0] value;
      logic [7:0]  rep_count;
      logic [31:0] first_index;
      logic        done;
   } record_type;

endpackage

`default_nettype wire

@@ rtl/tgad_parser.sv @@
// Front end: byte classifier, header parser and pixel/packet sequencer.
`default_nettype none

module tgad_parser (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  byte_valid,
   input  wire  [7:0]           byte_data,
   input  wire                  byte_sof,
   output logic                 rec_valid,
   output tgad_pkg::record_type rec_data
);
   import tgad_pkg::*;

   // Parse phases.
   localparam logic [2:0] PH_HEADER   = 3'd0;
   localparam logic [2:0] PH_IDENT    = 3'd1;
   localparam logic [2:0] PH_RAW      = 3'd2;
   localparam logic [2:0] PH_PKT_HEAD = 3'd3;
   localparam logic [2:0] PH_PKT_PIX  = 3'd4;
   localparam logic [2:0] PH_IDLE     = 3'd5;

   // Header byte positions that carry fields.
   localparam logic [4:0] HB_IDENT     = 5'd0;
   localparam logic [4:0] HB_TYPE      = 5'd2;
   localparam logic [4:0] HB_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HB_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HB_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HB_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HB_DEPTH     = 5'd16;
   localparam logic [4:0] HB_LAST      = 5'd17;

   // Image type codes.
   localparam logic [7:0] TYPE_TRUE_RAW = 8'd2;
   localparam logic [7:0] TYPE_GRAY_RAW = 8'd3;
   localparam logic [7:0] TYPE_TRUE_RLE = 8'd10;
   localparam logic [7:0] TYPE_GRAY_RLE = 8'd11;

   localparam logic [7:0] PKT_RUN_BIT  = 8'd128;
   localparam logic [7:0] PKT_RUN_BIAS = 8'd127;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  ident_ff, ident_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [4:0]  depth_ff, depth_in;
   logic [2:0]  bpp_ff, bpp_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] counter_ff, counter_in;
   logic [7:0]  pkt_rem_ff, pkt_rem_in;
   logic        pkt_run_ff, pkt_run_in;
   logic [31:0] asm_ff, asm_in;
   logic [1:0]  bip_ff, bip_in;
   logic [31:0] area_ff;

   logic [2:0]  cur_phase;
   logic [4:0]  cur_cnt;
   logic        compressed;
   logic        type_ok;
   logic        depth_ok;
   logic [31:0] asm_gather;
   logic [1:0]  bip_next;
   logic        pix_complete;
   logic        rem_small;
   logic [7:0]  run_rep;
   logic        run_done;
   logic [7:0]  ident_dec;
   logic [7:0]  pkt_dec;

   // Image area, refreshed every cycle; stable by the last header byte.
   always_ff @(posedge clock) begin
      area_ff <= 32'(width_ff) * 32'(height_ff);
   end

   // Shared decode of the current state.
   always_comb begin
      cur_phase    = byte_sof ? PH_HEADER : phase_ff;
      cur_cnt      = byte_sof ? 5'd0 : hdr_cnt_ff;
      compressed   = (type_ff == TYPE_TRUE_RLE) || (type_ff == TYPE_GRAY_RLE);
      type_ok      = (type_ff == TYPE_TRUE_RAW) || (type_ff == TYPE_GRAY_RAW) || compressed;
      depth_ok     = (depth_ff == 5'd1) || (depth_ff == 5'd3) || (depth_ff == 5'd4);
      asm_gather   = asm_ff | ({24'd0, byte_data} << {bip_ff, 3'b000});
      bip_next     = bip_ff + 2'd1;
      pix_complete = (bip_next == bpp_ff[1:0]);
      // A run is clipped only when fewer pixels than its length remain.
      rem_small    = (remain_ff[31:8] == 24'd0);
      run_rep      = (rem_small && (remain_ff[7:0] < pkt_rem_ff)) ? remain_ff[7:0]
                                                                  : pkt_rem_ff;
      run_done     = rem_small && (remain_ff[7:0] <= pkt_rem_ff);
      ident_dec    = ident_ff - 8'd1;
      pkt_dec      = pkt_rem_ff - 8'd1;
   end

   // Next state and result record for the accepted byte.
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      ident_in   = ident_ff;
      type_in    = type_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      depth_in   = depth_ff;
      bpp_in     = bpp_ff;
      remain_in  = remain_ff;
      counter_in = counter_ff;
      pkt_rem_in = pkt_rem_ff;
      pkt_run_in = pkt_run_ff;
      asm_in     = asm_ff;
      bip_in     = bip_ff;

      rec_valid            = 1'b0;
      rec_data             = '0;
      rec_data.kind        = KIND_PIXEL;
      rec_data.width       = width_ff;
      rec_data.height      = height_ff;
      rec_data.pixel_bytes = bpp_ff;
      rec_data.compressed  = compressed;
      rec_data.value       = asm_gather;
      rec_data.rep_count   = 8'd1;
      rec_data.first_index = counter_ff;
      rec_data.done        = (remain_ff == 32'd1);

      if (byte_valid) begin
         phase_in   = cur_phase;
         hdr_cnt_in = cur_cnt;
         unique case (cur_phase)
            PH_HEADER: begin
               case (cur_cnt)
                  HB_IDENT:     ident_in         = byte_data;
                  HB_TYPE:      type_in          = byte_data;
                  HB_WIDTH_LO:  width_in[7:0]    = byte_data;
                  HB_WIDTH_HI:  width_in[15:8]   = byte_data;
                  HB_HEIGHT_LO: height_in[7:0]   = byte_data;
                  HB_HEIGHT_HI: height_in[15:8]  = byte_data;
                  HB_DEPTH:     depth_in         = byte_data[7:3];
                  default:      ;
               endcase
               if (cur_cnt >= HB_LAST) begin
                  hdr_cnt_in           = 5'd0;
                  rec_valid            = 1'b1;
                  rec_data.value       = '0;
                  rec_data.rep_count   = '0;
                  rec_data.first_index = '0;
                  rec_data.done        = 1'b0;
                  if (!type_ok || width_ff == 16'd0 || height_ff == 16'd0 || !depth_ok) begin
                     rec_data.kind        = KIND_ERROR;
                     rec_data.pixel_bytes = '0;
                     rec_data.compressed  = 1'b0;
                     if (!type_ok) begin
                        rec_data.err = ERR_BAD_TYPE;
                     end else if (width_ff == 16'd0 || height_ff == 16'd0) begin
                        rec_data.err = ERR_ZERO_DIM;
                     end else begin
                        rec_data.err = ERR_BAD_DEPTH;
                     end
                     phase_in = PH_IDLE;
                  end else begin
                     rec_data.kind        = KIND_HEADER;
                     rec_data.pixel_bytes = depth_ff[2:0];
                     bpp_in               = depth_ff[2:0];
                     remain_in            = area_ff;
                     counter_in           = '0;
                     asm_in               = '0;
                     bip_in               = '0;
                     if (ident_ff != 8'd0) begin
                        phase_in = PH_IDENT;
                     end else begin
                        phase_in = compressed ? PH_PKT_HEAD : PH_RAW;
                     end
                  end
               end else begin
                  hdr_cnt_in = cur_cnt + 5'd1;
               end
            end
            PH_IDENT: begin
               ident_in = ident_dec;
               if (ident_dec == 8'd0) begin
                  phase_in = compressed ? PH_PKT_HEAD : PH_RAW;
               end
            end
            PH_RAW, PH_PKT_PIX: begin
               if (pix_complete) begin
                  rec_valid = 1'b1;
                  asm_in    = '0;
                  bip_in    = '0;
                  if (cur_phase == PH_PKT_PIX && pkt_run_ff) begin
                     rec_data.rep_count = run_rep;
                     rec_data.done      = run_done;
                     pkt_rem_in         = '0;
                     phase_in           = PH_PKT_HEAD;
                  end else if (cur_phase == PH_PKT_PIX) begin
                     pkt_rem_in = pkt_dec;
                     phase_in   = (pkt_dec == 8'd0) ? PH_PKT_HEAD : PH_PKT_PIX;
                  end
                  counter_in = counter_ff + 32'(rec_data.rep_count);
                  remain_in  = remain_ff - 32'(rec_data.rep_count);
                  if (rec_data.done) begin
                     phase_in = PH_IDLE;
                  end
               end else begin
                  asm_in = asm_gather;
                  bip_in = bip_next;
               end
            end
            PH_PKT_HEAD: begin
               if (byte_data < PKT_RUN_BIT) begin
                  pkt_run_in = 1'b0;
                  pkt_rem_in = byte_data + 8'd1;
               end else begin
                  pkt_run_in = 1'b1;
                  pkt_rem_in = byte_data - PKT_RUN_BIAS;
               end
               asm_in   = '0;
               bip_in   = '0;
               phase_in = PH_PKT_PIX;
            end
            default: ;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_cnt_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
      end
   end

   // Header fields, counters and pixel assembly.
   always_ff @(posedge clock) begin
      ident_ff   <= ident_in;
      type_ff    <= type_in;
      width_ff   <= width_in;
      height_ff  <= height_in;
      depth_ff   <= depth_in;
      bpp_ff     <= bpp_in;
      remain_ff  <= remain_in;
      counter_ff <= counter_in;
      pkt_rem_ff <= pkt_rem_in;
      pkt_run_ff <= pkt_run_in;
      asm_ff     <= asm_in;
      bip_ff     <= bip_in;
   end

endmodule

`default_nettype wire

@@ rtl/tgad_queue.sv @@
// Short record queue between the parser and the output stage.
`default_nettype none

module tgad_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  tgad_pkg::record_type push_data,
   output logic                 full,
   output logic                 head_valid,
   output tgad_pkg::record_type head_data,
   input  wire                  pop
);
   import tgad_pkg::*;

   record_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic                do_push;
   logic                do_pop;

   assign full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QPTR_W + 1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QPTR_W + 1)'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/tgad_out_stage.sv @@
// Back end: output register that formats records into result beats.
`default_nettype none

module tgad_out_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  tgad_pkg::record_type head_data,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [111:0]         rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import tgad_pkg::*;

   logic       valid_ff;
   record_type rec_ff;

   // Load a new record whenever the register is empty or being drained.
   assign pop = head_valid && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || rsp_tready) begin
         valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rec_ff <= head_data;
      end
   end

   // Beat packing, highest field first.
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, rec_ff.first_index, rec_ff.rep_count, rec_ff.value,
                        rec_ff.compressed, rec_ff.pixel_bytes, rec_ff.height,
                        rec_ff.width, rec_ff.err};
   assign rsp_tuser  = rec_ff.kind;
   assign rsp_tlast  = rec_ff.done;

endmodule

`default_nettype wire

@@ rtl/tga_image_stream_decoder_core.sv @@
// Top level of the TGA stream decoder.
`default_nettype none

// Decodes a TGA file that arrives one byte per beat on the req channel and
// gives header, error and pixel records on the rsp channel. A byte is taken
// every cycle while the queue is not full; the parser finishes each byte in
// the cycle it is accepted and writes its record, if any, into a four-entry
// queue, from which an output register feeds the rsp channel, one record
// per cycle while rsp_tready is high. A record reaches rsp through the
// queue and the output register. req_tready drops only while the queue is
// full, that is while rsp is stalled. After an error or a finished image,
// bytes are swallowed until req_tuser marks the first byte of a new file.
// Run packets give one record with a repeat count, clipped at image end.
module tga_image_stream_decoder_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [7:0]   req_tdata,   // file_byte
   input  wire          req_tuser,   // start_of_file
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // error_code[1:0], image_width[17:2], image_height[33:18],
   // pixel_bytes[36:34], is_compressed[37], pixel_value[69:38],
   // repeat_count[77:70], first_pixel_index[109:78], zero fill[111:110]
   output logic [111:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // record_kind
   output logic         rsp_tlast    // image_done
);
   import tgad_pkg::*;

   logic       q_full;
   logic       accept;
   logic       rec_valid;
   record_type rec_data;
   logic       head_valid;
   record_type head_data;
   logic       pop;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   tgad_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .byte_data  (req_tdata),
      .byte_sof   (req_tuser),
      .rec_valid  (rec_valid),
      .rec_data   (rec_data)
   );

   tgad_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (rec_valid),
      .push_data  (rec_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   tgad_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/tgad_checker.sv @@
// Port-level checks on the decoder's result channel, bound to the top level.
`default_nettype none

module tgad_checker (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [111:0] rsp_tdata,
   input wire [1:0]   rsp_tuser,
   input wire         rsp_tlast
);
   import tgad_pkg::*;

   // A stalled result beat stays and holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // Pixel records always cover at least one pixel and carry no error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_PIXEL |->
      rsp_tdata[77:70] != 8'd0 && rsp_tdata[1:0] == ERR_NONE &&
      (rsp_tdata[36:34] == 3'd1 || rsp_tdata[36:34] == 3'd3 || rsp_tdata[36:34] == 3'd4))
      else $error("malformed pixel record");

   // Error records carry a code, have no pixel bytes and never end an image.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |->
      rsp_tdata[1:0] != ERR_NONE && !rsp_tlast && rsp_tdata[36:34] == 3'd0)
      else $error("malformed error record");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind tga_image_stream_decoder_core tgad_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
